// ===== sv/tf3_pkg.sv =====
package tf3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int HEIGHT_MAX    = 4096;
  localparam int MIN_DIM       = 3;
  localparam int BORDER        = 2;

  localparam int PIX_W      = 8;
  localparam int WGT_W      = 8;
  localparam int ROW_WGT_W  = 3 * WGT_W;
  localparam int SCALE_W    = 24;
  localparam int OFFSET_W   = 11;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int TAP_NUM    = 9;
  localparam int TAP_W      = 4;
  localparam int MPROD_W    = WGT_W + PIX_W + 1;
  localparam int ACC_W      = 20;
  localparam int PROD_W     = ACC_W + SCALE_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;
  localparam int PIX_MAX    = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHTS_TOP    = 3'd0,
    REG_WEIGHTS_MIDDLE = 3'd1,
    REG_WEIGHTS_BOTTOM = 3'd2,
    REG_SCALE_FACTOR   = 3'd3,
    REG_OFFSET         = 3'd4,
    REG_FILTER_MODE    = 3'd5,
    REG_IMAGE_WIDTH    = 3'd6,
    REG_IMAGE_HEIGHT   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_WGT_W-1:0]       w_top;
    logic [ROW_WGT_W-1:0]       w_mid;
    logic [ROW_WGT_W-1:0]       w_bot;
    logic signed [SCALE_W-1:0]  scale;
    logic signed [OFFSET_W-1:0] offset;
    logic                       bright_mode;
    logic [IMG_W_W-1:0]         img_width;
    logic [IMG_H_W-1:0]         img_height;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             rd_en;
    logic             mac_en;
    logic [TAP_W-1:0] tap;
    logic             scale_en;
    logic             offs_en;
    logic             finish;
  } cmd_t;

endpackage

// ===== sv/tf3_if.sv =====
interface tf3_pix_if;
  logic                       valid;
  logic                       ready;
  logic [tf3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface tf3_res_if;
  logic                       valid;
  logic                       ready;
  logic [tf3_pkg::PIX_W-1:0]  pixel_out;
  logic                       frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== sv/tf3_cfg.sv =====
module tf3_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tf3_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tf3_pkg::cfg_t                    cfg
);
  import tf3_pkg::*;

  cfg_t     cfg_r;
  cfg_reg_t reg_sel;

  assign reg_sel = cfg_reg_t'(cfg_index);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.w_top       <= ROW_WGT_W'(0);
      cfg_r.w_mid       <= ROW_WGT_W'(256);
      cfg_r.w_bot       <= ROW_WGT_W'(0);
      cfg_r.scale       <= -SCALE_W'(65536);
      cfg_r.offset      <= OFFSET_W'(255);
      cfg_r.bright_mode <= 1'b0;
      cfg_r.img_width   <= IMG_W_W'(640);
      cfg_r.img_height  <= IMG_H_W'(480);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_WEIGHTS_TOP:    cfg_r.w_top       <= cfg_data[ROW_WGT_W-1:0];
        REG_WEIGHTS_MIDDLE: cfg_r.w_mid       <= cfg_data[ROW_WGT_W-1:0];
        REG_WEIGHTS_BOTTOM: cfg_r.w_bot       <= cfg_data[ROW_WGT_W-1:0];
        REG_SCALE_FACTOR:   cfg_r.scale       <= signed'(cfg_data[SCALE_W-1:0]);
        REG_OFFSET:         cfg_r.offset      <= signed'(cfg_data[OFFSET_W-1:0]);
        REG_FILTER_MODE:    cfg_r.bright_mode <= cfg_data[0];
        REG_IMAGE_WIDTH:    cfg_r.img_width   <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_r.img_height  <= cfg_data[IMG_H_W-1:0];
        default:            cfg_r             <= cfg_r;
      endcase
    end
  end

endmodule

// ===== sv/tf3_ctrl.sv =====
module tf3_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output tf3_pkg::cmd_t  cmd
);
  import tf3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_OFFS,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  // The result register is free when empty or being drained in this cycle.
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.rd_en    = accept;
    cmd.mac_en   = (state_r == ST_MAC);
    cmd.tap      = tap_r;
    cmd.scale_en = (state_r == ST_SCALE);
    cmd.offs_en  = (state_r == ST_OFFS);
    cmd.finish   = load_out;
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        tap_nxt = '0;
        if (accept) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        tap_nxt = tap_r + TAP_W'(1);
        if (tap_r == TAP_W'(TAP_NUM - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_OFFS;
      ST_OFFS:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/tf3_dp.sv =====
module tf3_dp #(
  parameter int MaxWidth = tf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tf3_pkg::cfg_t               cfg,
  input  tf3_pkg::cmd_t               cmd,
  input  logic [tf3_pkg::PIX_W-1:0]   in_pixel,
  output logic [tf3_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_frame_end
);
  import tf3_pkg::*;

  localparam int CW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  // Line stores: the row above and the row two above the current pixel.
  logic [PIX_W-1:0] prev_mem  [MaxWidth];
  logic [PIX_W-1:0] older_mem [MaxWidth];
  logic [PIX_W-1:0] up1_r, up2_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] taps_r [6];

  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  p_r;
  logic [PIX_W-1:0]         out_pix_r;
  logic                     out_fe_r;

  logic [PIX_W-1:0]          sel_pix;
  logic [WGT_W-1:0]          sel_wgt;
  logic signed [MPROD_W-1:0] mac_prod;
  logic signed [SUM_W-1:0]   off_q;
  logic [SUM_W-1:0]          mag_rnd;
  logic [PIX_W-1:0]          filt_pix;
  logic signed [OFFSET_W:0]  bright_sum;
  logic [PIX_W-1:0]          bright_pix;
  logic                      border;
  logic [PIX_W-1:0]          result;

  logic [EW-1:0]      width_eff;
  logic [IMG_H_W-1:0] height_eff;
  logic               row_end;
  logic               last_row;

  assign out_pixel     = out_pix_r;
  assign out_frame_end = out_fe_r;

  // Effective geometry, clamped to the supported range.
  always_comb begin
    if (EW'(cfg.img_width) < EW'(MIN_DIM)) begin
      width_eff = EW'(MIN_DIM);
    end else if (EW'(cfg.img_width) > EW'(MaxWidth)) begin
      width_eff = EW'(MaxWidth);
    end else begin
      width_eff = EW'(cfg.img_width);
    end
    if (cfg.img_height < IMG_H_W'(MIN_DIM)) begin
      height_eff = IMG_H_W'(MIN_DIM);
    end else if (cfg.img_height > IMG_H_W'(HEIGHT_MAX)) begin
      height_eff = IMG_H_W'(HEIGHT_MAX);
    end else begin
      height_eff = cfg.img_height;
    end
  end

  assign row_end  = (EW'(col_r) + EW'(1)) >= width_eff;
  assign last_row = (IMG_H_W'(row_r) + IMG_H_W'(1)) >= height_eff;

  // Window walk: top row, then middle, then bottom, left to right.
  always_comb begin
    case (cmd.tap)
      4'd0:    begin sel_pix = taps_r[0]; sel_wgt = cfg.w_top[7:0];   end
      4'd1:    begin sel_pix = taps_r[1]; sel_wgt = cfg.w_top[15:8];  end
      4'd2:    begin sel_pix = up2_r;     sel_wgt = cfg.w_top[23:16]; end
      4'd3:    begin sel_pix = taps_r[2]; sel_wgt = cfg.w_mid[7:0];   end
      4'd4:    begin sel_pix = taps_r[3]; sel_wgt = cfg.w_mid[15:8];  end
      4'd5:    begin sel_pix = up1_r;     sel_wgt = cfg.w_mid[23:16]; end
      4'd6:    begin sel_pix = taps_r[4]; sel_wgt = cfg.w_bot[7:0];   end
      4'd7:    begin sel_pix = taps_r[5]; sel_wgt = cfg.w_bot[15:8];  end
      4'd8:    begin sel_pix = pix_r;     sel_wgt = cfg.w_bot[23:16]; end
      default: begin sel_pix = '0;        sel_wgt = '0;               end
    endcase
  end

  assign mac_prod = MPROD_W'(signed'(sel_wgt)) * signed'({1'b0, sel_pix});

  assign off_q = SUM_W'(cfg.offset) <<< FRAC_BITS;

  // Magnitude plus one half: for negative p, -p + half equals ~p + half + 1.
  always_comb begin
    if (p_r[SUM_W-1]) begin
      mag_rnd = ~p_r + SUM_W'(ROUND_HALF + 1);
    end else begin
      mag_rnd = p_r + SUM_W'(ROUND_HALF);
    end
    if (|mag_rnd[SUM_W-1:FRAC_BITS+PIX_W]) begin
      filt_pix = PIX_W'(PIX_MAX);
    end else begin
      filt_pix = mag_rnd[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  assign bright_sum = signed'({{(OFFSET_W + 1 - PIX_W){1'b0}}, pix_r})
                    + (OFFSET_W + 1)'(cfg.offset);

  always_comb begin
    if (bright_sum < 0) begin
      bright_pix = '0;
    end else if (bright_sum > (OFFSET_W + 1)'(PIX_MAX)) begin
      bright_pix = PIX_W'(PIX_MAX);
    end else begin
      bright_pix = bright_sum[PIX_W-1:0];
    end
  end

  assign border = (row_r < ROW_W'(BORDER)) || (col_r < CW'(BORDER));

  always_comb begin
    if (cfg.bright_mode) begin
      result = bright_pix;
    end else if (border) begin
      result = pix_r;
    end else begin
      result = filt_pix;
    end
  end

  // Line stores are read when a beat is taken and written back when it finishes.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      up1_r <= prev_mem[col_r];
      up2_r <= older_mem[col_r];
    end
    if (cmd.finish) begin
      older_mem[col_r] <= up1_r;
      prev_mem[col_r]  <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pix_r <= in_pixel;
    end
    if (cmd.mac_en) begin
      acc_r <= ((cmd.tap == '0) ? ACC_W'(0) : acc_r) + ACC_W'(mac_prod);
    end
    if (cmd.scale_en) begin
      prod_r <= PROD_W'(acc_r) * PROD_W'(cfg.scale);
    end
    if (cmd.offs_en) begin
      p_r <= SUM_W'(prod_r) + off_q;
    end
    if (cmd.finish) begin
      taps_r[0] <= taps_r[1];
      taps_r[1] <= up2_r;
      taps_r[2] <= taps_r[3];
      taps_r[3] <= up1_r;
      taps_r[4] <= taps_r[5];
      taps_r[5] <= pix_r;
      out_pix_r <= result;
      out_fe_r  <= row_end && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.finish) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

endmodule

// ===== sv/template_filter_3x3_top.sv =====
// A pixel beat is taken only in the idle state; out_valid rises when its result is
// loaded into the result register, once that register is empty or draining, and no
// new beat is taken before then. A single shared multiply-accumulate walks the nine
// window taps one per cycle, followed by the scale, offset and round steps.
// Reset (rst_n, synchronous, active low) clears the controller, the frame position
// and the configuration registers; line stores and window taps hold no reset value.
module template_filter_3x3_top #(
  parameter int MAX_WIDTH = tf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  tf3_pix_if.sink                          in_ch,
  tf3_res_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tf3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tf3_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tf3_pkg::*;

  // The configuration block holds the eight registers. Writes are expected only
  // while no pixel is in flight, so the datapath reads them directly.
  cfg_t cfg;
  cmd_t cmd;

  tf3_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The controller sequences one pixel at a time: accept and read the line stores,
  // nine multiply-accumulate steps, the scale multiply, the offset add, and finally
  // rounding, saturation and the load of the result register. The result register
  // parts the two channels, so a new beat is taken while a result is still waiting.
  tf3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath owns the two line stores, the six window taps, the frame position
  // and the arithmetic. Border pixels and brightness mode bypass the filter result
  // at the last step, while stores and position advance on every pixel.
  tf3_dp #(
    .MaxWidth (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .in_pixel      (in_ch.pixel_in),
    .out_pixel     (out_ch.pixel_out),
    .out_frame_end (out_ch.frame_end)
  );

endmodule
